// ===== src/dwpid_pkg.sv =====
// ----------------------------------------------------------------------------
// dwpid_pkg
// Shared types, constants and the saturating gain multiply for the dual-wheel
// PID speed loop.
// ----------------------------------------------------------------------------
package dwpid_pkg;

   // Fixed-point format of speeds and loop terms
   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 8;
   localparam int OUT_MAX_W  = 8;
   localparam int DUTY_W     = 8;

   // Shift low-pass filters
   localparam int VEL_SHIFT  = 3;
   localparam int FF_SHIFT   = 3;
   localparam int SLEW_SHIFT = 2;

   // Command limit before saturation to the largest positive value
   localparam int LIM_WIDE_W = OUT_MAX_W + FRAC_BITS;
   localparam logic [DATA_W-2:0] MAX_POS = '1;

   // Gain multiply widths: unsigned gain times 33-bit signed operand
   localparam int PROD_W = GAIN_W + 1 + DATA_W + 1;
   localparam int SHR_W  = PROD_W - GAIN_FRAC;

   // Pipeline stages of one lane
   localparam int NUM_STAGES = 5;
   localparam int STG_RAMP   = 0;
   localparam int STG_MUL    = 1;
   localparam int STG_ACC    = 2;
   localparam int STG_SUM    = 3;
   localparam int STG_OUT    = 4;

   // Register map
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP         = 3'd0,
      CSR_KI_DT      = 3'd1,
      CSR_KD_OVER_DT = 3'd2,
      CSR_K_FF       = 3'd3,
      CSR_RAMP_STEP  = 3'd4,
      CSR_HOLD_BAND  = 3'd5,
      CSR_OUT_MAX    = 3'd6
   } csr_idx_type;

   localparam logic [GAIN_W-1:0]    KP_RST        = 16'd256;
   localparam logic [GAIN_W-1:0]    GAIN_ZERO     = '0;
   localparam logic [DATA_W-2:0]    RAMP_STEP_RST = 31'd65536;
   localparam logic [DATA_W-2:0]    HOLD_BAND_RST = '0;
   localparam logic [OUT_MAX_W-1:0] OUT_MAX_RST   = 8'd255;

   typedef struct packed {
      logic [GAIN_W-1:0]    kp;
      logic [GAIN_W-1:0]    ki_dt;
      logic [GAIN_W-1:0]    kd_over_dt;
      logic [GAIN_W-1:0]    k_ff;
      logic [DATA_W-2:0]    ramp_step;
      logic [DATA_W-2:0]    hold_band;
      logic [OUT_MAX_W-1:0] out_max;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] target_left;
      logic signed [DATA_W-1:0] target_right;
      logic signed [DATA_W-1:0] measured_left;
      logic signed [DATA_W-1:0] measured_right;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_left;
      logic              reverse_left;
      logic [DUTY_W-1:0] duty_right;
      logic              reverse_right;
   } rsp_type;

   // Per-stage load strobes shared by both lanes
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctl_type;

   // Unsigned Q8.8 gain times signed operand, floor shift, saturate to 32 bits
   function automatic logic signed [DATA_W-1:0] gain_mul(
      input logic [GAIN_W-1:0]  g,
      input logic signed [DATA_W:0] x
   );
      logic signed [PROD_W-1:0] prod;
      logic signed [SHR_W-1:0]  shr;
      logic signed [DATA_W-1:0] res;
      prod = PROD_W'($signed({1'b0, g})) * PROD_W'(x);
      shr  = prod[PROD_W-1:GAIN_FRAC];
      if ((&shr[SHR_W-1:DATA_W-1]) || !(|shr[SHR_W-1:DATA_W-1])) begin
         res = shr[DATA_W-1:0];
      end else if (shr[SHR_W-1]) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ===== src/dwpid_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwpid_ctrl
// Stage valid tracking and stall propagation for the lane pipelines.
// ----------------------------------------------------------------------------
module dwpid_ctrl
   import dwpid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output stage_ctl_type ctl
);

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] ready;
   logic [NUM_STAGES-1:0] upstream;

   assign upstream = {vld_ff[NUM_STAGES-2:0], req_valid};

   // A stage can take a transfer when empty or when its item moves on
   always_comb begin
      ready[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !vld_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         ctl.load[i] = upstream[i] && ready[i];
         vld_in[i]   = ready[i] ? upstream[i] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

`ifndef NO_ASSERTIONS
   a_load_from_valid: assert property (@(posedge clock) disable iff (reset)
      (ctl.load & ~upstream) == '0)
      else $error("stage loaded from an empty upstream stage");

   a_bubble_accepts: assert property (@(posedge clock) disable iff (reset)
      (vld_ff != '1) |-> !req_stall)
      else $error("input stalled while the pipeline has a bubble");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && rsp_stall) |-> req_stall)
      else $error("input taken while the pipeline is full and blocked");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      !reset |=> $countones(vld_ff) == $past($countones(vld_ff))
         + $past(req_valid && !req_stall) - $past(rsp_valid && !rsp_stall))
      else $error("item lost or duplicated in the pipeline");
`endif

endmodule

// ===== src/dwpid_lane.sv =====
// ----------------------------------------------------------------------------
// dwpid_lane
// One wheel's speed loop: ramp and filter, gain products, integral and
// feed-forward update, PID sum, then clamp, hold and command slew.
// ----------------------------------------------------------------------------
module dwpid_lane
   import dwpid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  stage_ctl_type            ctl,
   input  logic signed [DATA_W-1:0] target,
   input  logic signed [DATA_W-1:0] measured,
   output logic [DUTY_W-1:0]        duty,
   output logic                     reverse
);

   // Loop state, one update per item in its own stage
   logic signed [DATA_W-1:0] ref_ff, spd_ff, ff_ff, integ_ff, cmd_ff;
   logic signed [DATA_W-1:0] ref_in, spd_in, ff_in, integ_in, cmd_in;

   // Pipeline payload
   logic signed [DATA_W:0]   err_ff, dspd_ff;
   logic signed [DATA_W-1:0] pff_ff, pi_ff, pp_ff, pd_ff;
   logic                     hold_s2_ff;
   logic signed [DATA_W-1:0] pp_s3_ff, pd_s3_ff;
   logic                     hold_s3_ff;
   logic signed [DATA_W+1:0] sum_ff;
   logic                     hold_s4_ff;
   logic [DUTY_W-1:0]        duty_ff;
   logic                     rev_ff;

   // Command limit
   logic [LIM_WIDE_W-1:0] lim_wide;
   logic [DATA_W:0]       lim_ext;
   logic [DATA_W-2:0]     lim;

   assign lim_wide = {cfg.out_max, {FRAC_BITS{1'b0}}};
   assign lim_ext  = (DATA_W+1)'(lim_wide);
   assign lim      = (lim_ext > (DATA_W+1)'(MAX_POS)) ? MAX_POS : lim_ext[DATA_W-2:0];

   // Ramp and speed filter
   logic signed [DATA_W+1:0] ref_x, tgt_x, ref_up, ref_dn;
   logic signed [DATA_W:0]   spd_diff, spd_step, spd_sum, err_in, dspd_in;

   assign ref_x  = {{2{ref_ff[DATA_W-1]}}, ref_ff};
   assign tgt_x  = {{2{target[DATA_W-1]}}, target};
   assign ref_up = ref_x + $signed({3'b000, cfg.ramp_step});
   assign ref_dn = ref_x - $signed({3'b000, cfg.ramp_step});

   always_comb begin
      priority if (ref_up < tgt_x) begin
         ref_in = ref_up[DATA_W-1:0];
      end else if (ref_dn > tgt_x) begin
         ref_in = ref_dn[DATA_W-1:0];
      end else begin
         ref_in = target;
      end
   end

   assign spd_diff = {measured[DATA_W-1], measured} - {spd_ff[DATA_W-1], spd_ff};
   assign spd_step = spd_diff >>> VEL_SHIFT;
   assign spd_sum  = {spd_ff[DATA_W-1], spd_ff} + spd_step;
   assign spd_in   = spd_sum[DATA_W-1:0];
   assign err_in   = {ref_in[DATA_W-1], ref_in} - {spd_in[DATA_W-1], spd_in};
   // Derivative on the measurement: last speed is the previous filtered value
   assign dspd_in  = {spd_in[DATA_W-1], spd_in} - {spd_ff[DATA_W-1], spd_ff};

   // Error magnitude for the hold window
   logic [DATA_W:0] err_bits, err_abs;
   logic            hold_in;

   assign err_bits = err_ff;
   assign err_abs  = err_bits[DATA_W] ? -err_bits : err_bits;
   assign hold_in  = err_abs < {2'b00, cfg.hold_band};

   // Feed-forward smoothing and clamped integral
   logic signed [DATA_W:0] ff_diff, ff_step, ff_sum;
   logic signed [DATA_W:0] integ_sum, lim_pos, lim_neg;

   assign ff_diff = {pff_ff[DATA_W-1], pff_ff} - {ff_ff[DATA_W-1], ff_ff};
   assign ff_step = ff_diff >>> FF_SHIFT;
   assign ff_sum  = {ff_ff[DATA_W-1], ff_ff} + ff_step;
   assign ff_in   = ff_sum[DATA_W-1:0];

   assign integ_sum = {integ_ff[DATA_W-1], integ_ff} + {pi_ff[DATA_W-1], pi_ff};
   assign lim_pos   = $signed({2'b00, lim});
   assign lim_neg   = -lim_pos;

   always_comb begin
      priority if (integ_sum > lim_pos) begin
         integ_in = lim_pos[DATA_W-1:0];
      end else if (integ_sum < lim_neg) begin
         integ_in = lim_neg[DATA_W-1:0];
      end else begin
         integ_in = integ_sum[DATA_W-1:0];
      end
   end

   // PID sum
   logic signed [DATA_W+1:0] sum_in;

   assign sum_in = {{2{ff_ff[DATA_W-1]}}, ff_ff} + {{2{pp_s3_ff[DATA_W-1]}}, pp_s3_ff}
                 + {{2{integ_ff[DATA_W-1]}}, integ_ff}
                 - {{2{pd_s3_ff[DATA_W-1]}}, pd_s3_ff};

   // Hold, clamp and slew of the drive command
   logic signed [DATA_W+1:0] cmd_x, cmd_sel, cmd_clip, lim2_pos, lim2_neg;
   logic signed [DATA_W+2:0] cmd_delta, cmd_step, cmd_sum;
   logic [DATA_W-1:0]        cmd_bits, cmd_mag;

   assign cmd_x    = {{2{cmd_ff[DATA_W-1]}}, cmd_ff};
   assign cmd_sel  = hold_s4_ff ? cmd_x : sum_ff;
   assign lim2_pos = $signed({3'b000, lim});
   assign lim2_neg = -lim2_pos;

   always_comb begin
      priority if (cmd_sel > lim2_pos) begin
         cmd_clip = lim2_pos;
      end else if (cmd_sel < lim2_neg) begin
         cmd_clip = lim2_neg;
      end else begin
         cmd_clip = cmd_sel;
      end
   end

   assign cmd_delta = {cmd_clip[DATA_W+1], cmd_clip} - {cmd_x[DATA_W+1], cmd_x};
   assign cmd_step  = cmd_delta >>> SLEW_SHIFT;
   assign cmd_sum   = {cmd_x[DATA_W+1], cmd_x} + cmd_step;
   assign cmd_in    = cmd_sum[DATA_W-1:0];
   assign cmd_bits  = cmd_in;
   assign cmd_mag   = cmd_bits[DATA_W-1] ? -cmd_bits : cmd_bits;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff   <= '0;
         spd_ff   <= '0;
         ff_ff    <= '0;
         integ_ff <= '0;
         cmd_ff   <= '0;
      end else begin
         if (ctl.load[STG_RAMP]) begin
            ref_ff <= ref_in;
            spd_ff <= spd_in;
         end
         if (ctl.load[STG_ACC]) begin
            ff_ff    <= ff_in;
            integ_ff <= integ_in;
         end
         if (ctl.load[STG_OUT]) begin
            cmd_ff <= cmd_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctl.load[STG_RAMP]) begin
         err_ff  <= err_in;
         dspd_ff <= dspd_in;
      end
      if (ctl.load[STG_MUL]) begin
         pff_ff     <= gain_mul(cfg.k_ff, {ref_ff[DATA_W-1], ref_ff});
         pi_ff      <= gain_mul(cfg.ki_dt, err_ff);
         pp_ff      <= gain_mul(cfg.kp, err_ff);
         pd_ff      <= gain_mul(cfg.kd_over_dt, dspd_ff);
         hold_s2_ff <= hold_in;
      end
      if (ctl.load[STG_ACC]) begin
         pp_s3_ff   <= pp_ff;
         pd_s3_ff   <= pd_ff;
         hold_s3_ff <= hold_s2_ff;
      end
      if (ctl.load[STG_SUM]) begin
         sum_ff     <= sum_in;
         hold_s4_ff <= hold_s3_ff;
      end
      if (ctl.load[STG_OUT]) begin
         duty_ff <= cmd_mag[FRAC_BITS+DUTY_W-1:FRAC_BITS];
         rev_ff  <= cmd_bits[DATA_W-1];
      end
   end

   assign duty    = duty_ff;
   assign reverse = rev_ff;

endmodule

// ===== src/dual_wheel_pid_speed_loop_core.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_pid_speed_loop_core
// Dual-wheel PID speed controller with feed-forward, one lane per wheel.
// ----------------------------------------------------------------------------
// Each tick carries left and right targets and measured speeds (signed Q16.16)
// and yields one duty and reverse bit per wheel. The two wheel lanes run side
// by side through a five-stage pipeline (ramp and filter, gain products,
// integral and feed-forward update, PID sum, clamp/hold/slew), so a new tick
// is taken every cycle while the result side does not stall; its result is
// registered through each of those stages in turn before it is offered.
// Each loop state register updates in its own stage, which keeps
// back-to-back ticks exact. A stall on the result side backs up through the
// stages and reaches the input once all five are full.
// Both lanes share one set of gains. Registers are written through the csr_
// port, which is always ready; write them only while no tick is in flight.
// ----------------------------------------------------------------------------
module dual_wheel_pid_speed_loop_core
   import dwpid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   cfg_type       cfg_ff;
   stage_ctl_type ctl;

   logic [DUTY_W-1:0] duty_l, duty_r;
   logic              rev_l, rev_r;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp         <= KP_RST;
         cfg_ff.ki_dt      <= GAIN_ZERO;
         cfg_ff.kd_over_dt <= GAIN_ZERO;
         cfg_ff.k_ff       <= GAIN_ZERO;
         cfg_ff.ramp_step  <= RAMP_STEP_RST;
         cfg_ff.hold_band  <= HOLD_BAND_RST;
         cfg_ff.out_max    <= OUT_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KP:         cfg_ff.kp         <= csr_wdata[GAIN_W-1:0];
            CSR_KI_DT:      cfg_ff.ki_dt      <= csr_wdata[GAIN_W-1:0];
            CSR_KD_OVER_DT: cfg_ff.kd_over_dt <= csr_wdata[GAIN_W-1:0];
            CSR_K_FF:       cfg_ff.k_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_RAMP_STEP:  cfg_ff.ramp_step  <= csr_wdata[DATA_W-2:0];
            CSR_HOLD_BAND:  cfg_ff.hold_band  <= csr_wdata[DATA_W-2:0];
            CSR_OUT_MAX:    cfg_ff.out_max    <= csr_wdata[OUT_MAX_W-1:0];
            default: begin
               // drop writes outside the register map
            end
         endcase
      end
   end

   dwpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   dwpid_lane u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .ctl      (ctl),
      .target   (req_data.target_left),
      .measured (req_data.measured_left),
      .duty     (duty_l),
      .reverse  (rev_l)
   );

   dwpid_lane u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .ctl      (ctl),
      .target   (req_data.target_right),
      .measured (req_data.measured_right),
      .duty     (duty_r),
      .reverse  (rev_r)
   );

   // Merge the lane results into one transfer
   always_comb begin
      rsp_data.duty_left     = duty_l;
      rsp_data.reverse_left  = rev_l;
      rsp_data.duty_right    = duty_r;
      rsp_data.reverse_right = rev_r;
   end

endmodule

// ===== verif/dwpid_duty_checker.sv =====
// ----------------------------------------------------------------------------
// dwpid_duty_checker
// Tracks the register writes and every accepted tick of the dual-wheel speed
// loop. It predicts both wheels' duty and direction with its own fixed-point
// loop model and checks each result transfer, in order, against that
// prediction.
// ----------------------------------------------------------------------------
module dwpid_duty_checker
   import dwpid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WORD_MAX     = 64'sh7FFF_FFFF;
   localparam longint WORD_MIN     = -64'sh8000_0000;
   localparam int     REPORT_LIMIT = 10;

   cfg_type gains;

   logic signed [DATA_W-1:0] ramp_ref   [2];
   logic signed [DATA_W-1:0] speed_filt [2];
   logic signed [DATA_W-1:0] ff_smooth  [2];
   logic signed [DATA_W-1:0] integ      [2];
   logic signed [DATA_W-1:0] prev_speed [2];
   logic signed [DATA_W-1:0] drive      [2];

   rsp_type duty_expect_q [$];
   int      errors;

   function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
      if (x < lo) begin
         return lo;
      end
      if (x > hi) begin
         return hi;
      end
      return x;
   endfunction

   // Q8.8 gain times operand, floor shift, saturate to a signed word
   function automatic longint scaled_gain(input logic [GAIN_W-1:0] g, input longint x);
      longint gv;
      longint prod;
      gv   = g;
      prod = (gv * x) >>> GAIN_FRAC;
      return clamp_range(prod, WORD_MIN, WORD_MAX);
   endfunction

   task automatic advance_wheel(
      input  int                       w,
      input  logic signed [DATA_W-1:0] tgt_in,
      input  logic signed [DATA_W-1:0] meas_in,
      output logic [DUTY_W-1:0]        duty,
      output logic                     rev
   );
      longint tgt, meas, lim, slew, hold_th;
      longint r, v, ff, err, sum, c, mag;
      tgt     = tgt_in;
      meas    = meas_in;
      lim     = gains.out_max;
      lim     = clamp_range(lim << FRAC_BITS, 0, WORD_MAX);
      slew    = gains.ramp_step;
      hold_th = gains.hold_band;

      r = ramp_ref[w];
      if (r + slew < tgt) begin
         r = r + slew;
      end else if (r - slew > tgt) begin
         r = r - slew;
      end else begin
         r = tgt;
      end
      ramp_ref[w] = DATA_W'(r);

      v = speed_filt[w];
      v = v + ((meas - v) >>> VEL_SHIFT);
      speed_filt[w] = DATA_W'(v);

      ff = ff_smooth[w];
      ff = ff + ((scaled_gain(gains.k_ff, r) - ff) >>> FF_SHIFT);
      ff_smooth[w] = DATA_W'(ff);

      err      = r - v;
      integ[w] = DATA_W'(clamp_range(integ[w] + scaled_gain(gains.ki_dt, err),
                                     -lim, lim));

      // derivative acts on the filtered measurement, not on the error
      sum = ff + scaled_gain(gains.kp, err) + integ[w]
            - scaled_gain(gains.kd_over_dt, v - prev_speed[w]);
      prev_speed[w] = DATA_W'(v);

      c = drive[w];
      if ((err < 0 ? -err : err) < hold_th) begin
         sum = c;
      end
      sum      = clamp_range(sum, -lim, lim);
      c        = c + ((sum - c) >>> SLEW_SHIFT);
      drive[w] = DATA_W'(c);

      mag  = c < 0 ? -c : c;
      duty = mag[FRAC_BITS +: DUTY_W];
      rev  = c < 0;
   endtask

   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         gains.kp         = KP_RST;
         gains.ki_dt      = GAIN_ZERO;
         gains.kd_over_dt = GAIN_ZERO;
         gains.k_ff       = GAIN_ZERO;
         gains.ramp_step  = RAMP_STEP_RST;
         gains.hold_band  = HOLD_BAND_RST;
         gains.out_max    = OUT_MAX_RST;
         for (int w = 0; w < 2; w++) begin
            ramp_ref[w]   = '0;
            speed_filt[w] = '0;
            ff_smooth[w]  = '0;
            integ[w]      = '0;
            prev_speed[w] = '0;
            drive[w]      = '0;
         end
         duty_expect_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_KP:         gains.kp         = csr_wdata[GAIN_W-1:0];
               CSR_KI_DT:      gains.ki_dt      = csr_wdata[GAIN_W-1:0];
               CSR_KD_OVER_DT: gains.kd_over_dt = csr_wdata[GAIN_W-1:0];
               CSR_K_FF:       gains.k_ff       = csr_wdata[GAIN_W-1:0];
               CSR_RAMP_STEP:  gains.ramp_step  = csr_wdata[DATA_W-2:0];
               CSR_HOLD_BAND:  gains.hold_band  = csr_wdata[DATA_W-2:0];
               CSR_OUT_MAX:    gains.out_max    = csr_wdata[OUT_MAX_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_wheel(0, req_data.target_left, req_data.measured_left,
                          want.duty_left, want.reverse_left);
            advance_wheel(1, req_data.target_right, req_data.measured_right,
                          want.duty_right, want.reverse_right);
            duty_expect_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (duty_expect_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result transfer L %0d/%0b R %0d/%0b", $time,
                           rsp_data.duty_left, rsp_data.reverse_left,
                           rsp_data.duty_right, rsp_data.reverse_right);
               end
            end else begin
               want = duty_expect_q.pop_front();
               if (rsp_data.duty_left !== want.duty_left ||
                   rsp_data.reverse_left !== want.reverse_left ||
                   rsp_data.duty_right !== want.duty_right ||
                   rsp_data.reverse_right !== want.reverse_right) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("%0t: duty mismatch, exp L %0d/%0b R %0d/%0b, got L %0d/%0b R %0d/%0b",
                              $time, want.duty_left, want.reverse_left,
                              want.duty_right, want.reverse_right,
                              rsp_data.duty_left, rsp_data.reverse_left,
                              rsp_data.duty_right, rsp_data.reverse_right);
                  end
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= duty_expect_q.size();
   end

endmodule

// ===== verif/dual_wheel_pid_speed_loop_core_tb.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_pid_speed_loop_core_tb
// Drives ticks and register settings into the dual-wheel speed loop with
// random gaps on both channels; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module dual_wheel_pid_speed_loop_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dwpid_pkg::*;

   localparam int S32_MAX     = 32'h7FFF_FFFF;
   localparam int S32_MIN     = 32'h8000_0000;
   localparam int PHASES      = 8;
   localparam int PHASE_TICKS = 135;
   localparam int BURST_TICKS = 40;
   localparam int LONG_HOLD   = 300;
   localparam int IDLE_LIMIT  = 4000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;
   int                   mismatch_count;
   int                   pending_count;

   int holds_asked;
   bit sender_quiet;
   int ticks_sent;
   int cruise_l;
   int cruise_r;

   dual_wheel_pid_speed_loop_core u_top (.*);

   dwpid_duty_checker u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
         return $urandom_range(1, 3);
      end else if (roll < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type tick(input int tl, input int tr, input int ml, input int mr);
      req_type t;
      t.target_left    = tl;
      t.target_right   = tr;
      t.measured_left  = ml;
      t.measured_right = mr;
      return t;
   endfunction

   function automatic int wide_speed();
      int n;
      n = $urandom_range(0, 400 << 16);
      return n - (200 << 16);
   endfunction

   function automatic int noise();
      int n;
      n = $urandom_range(0, 1 << 18);
      return n - (1 << 17);
   endfunction

   function automatic int corner();
      unique case ($urandom_range(0, 4))
         0:       return S32_MIN;
         1:       return S32_MAX;
         2:       return 0;
         3:       return -1;
         default: return 1;
      endcase
   endfunction

   // mostly a cruise speed that jumps now and then, with sensor noise; some raw words and corner values
   function automatic req_type random_tick();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 24) == 0) begin
         cruise_l = wide_speed();
         cruise_r = wide_speed();
      end
      if (kind < 7) begin
         return tick(cruise_l, cruise_r, cruise_l + noise(), cruise_r + noise());
      end else if (kind < 9) begin
         return {$urandom, $urandom, $urandom, $urandom};
      end
      return tick(corner(), corner(), corner(), corner());
   endfunction

   function automatic logic [31:0] pick_value(input bit mixed, input logic [31:0] top,
                                              input int unsigned lo, input int unsigned hi);
      int unsigned roll;
      roll = $urandom_range(0, 3);
      if (mixed && roll == 0) begin
         return '0;
      end
      if (mixed && roll == 1) begin
         return top;
      end
      return $urandom_range(hi, lo);
   endfunction

   function automatic cfg_type random_gains(input bit mixed);
      cfg_type c;
      c.kp         = GAIN_W'(pick_value(mixed, 32'hFFFF, 64, 4096));
      c.ki_dt      = GAIN_W'(pick_value(mixed, 32'hFFFF, 0, 512));
      c.kd_over_dt = GAIN_W'(pick_value(mixed, 32'hFFFF, 0, 1024));
      c.k_ff       = GAIN_W'(pick_value(mixed, 32'hFFFF, 0, 1024));
      c.ramp_step  = (DATA_W-1)'(pick_value(mixed, 32'(MAX_POS), 1, 1 << 18));
      c.hold_band  = ($urandom_range(0, 2) == 0) ? '0 :
                     (DATA_W-1)'(pick_value(mixed, 32'(MAX_POS), 0, 1 << 17));
      c.out_max    = OUT_MAX_W'(pick_value(mixed, 32'hFF, 1, 255));
      return c;
   endfunction

   // set bits above the register width now and then; they must be dropped
   function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
      if ($urandom_range(0, 1) == 0) begin
         return v;
      end
      return v | ($urandom << w);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_gains(input cfg_type c);
      write_reg(CSR_KP, with_junk(32'(c.kp), GAIN_W));
      write_reg(CSR_KI_DT, with_junk(32'(c.ki_dt), GAIN_W));
      write_reg(CSR_KD_OVER_DT, with_junk(32'(c.kd_over_dt), GAIN_W));
      write_reg(CSR_K_FF, with_junk(32'(c.k_ff), GAIN_W));
      write_reg(CSR_RAMP_STEP, with_junk(32'(c.ramp_step), DATA_W - 1));
      write_reg(CSR_HOLD_BAND, with_junk(32'(c.hold_band), DATA_W - 1));
      write_reg(CSR_OUT_MAX, with_junk(32'(c.out_max), OUT_MAX_W));
   endtask

   task automatic send_tick(input req_type t, input bit burst);
      int gap;
      gap = 0;
      if (!burst && !sender_quiet && $urandom_range(0, 2) == 0) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
      if (ticks_sent % 32 == 0) begin
         sender_quiet = ($urandom_range(0, 3) == 0);
      end
   endtask

   // hold off the input until every predicted result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin : stimulus
      cfg_type setting;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_KP;
      csr_wdata   <= '0;
      holds_asked <= 0;
      reset       <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // power-on settings: unit kp, unit-speed ramp, no hold
      send_tick(tick(0, 0, 0, 0), 1'b0);
      send_tick(tick(1000, -1000, 0, 0), 1'b0);
      send_tick(tick(S32_MAX, S32_MIN, 0, 0), 1'b0);
      send_tick(tick(S32_MAX, S32_MIN, S32_MAX, S32_MIN), 1'b0);
      send_tick(tick(S32_MIN, S32_MAX, S32_MIN, S32_MAX), 1'b0);
      send_tick(tick(0, 0, S32_MIN, S32_MAX), 1'b0);
      send_tick(tick(-1, 1, -1, 1), 1'b0);

      // every gain at full scale, unlimited ramp: products saturate
      drain();
      write_reg(CSR_UNMAPPED, $urandom);
      setting = '{kp: 16'hFFFF, ki_dt: 16'hFFFF, kd_over_dt: 16'hFFFF, k_ff: 16'hFFFF,
                  ramp_step: MAX_POS, hold_band: '0, out_max: 8'd255};
      set_gains(setting);
      send_tick(tick(S32_MAX, S32_MIN, S32_MIN, S32_MAX), 1'b0);
      send_tick(tick(S32_MIN, S32_MAX, S32_MAX, S32_MIN), 1'b0);
      send_tick(tick(S32_MAX, S32_MAX, S32_MIN, S32_MIN), 1'b0);
      send_tick(tick(0, 0, 0, 0), 1'b0);
      send_tick(tick(S32_MIN, S32_MIN, S32_MAX, S32_MAX), 1'b0);

      // zero output limit pins the integral to zero and slews the command toward zero
      drain();
      setting.out_max = '0;
      set_gains(setting);
      send_tick(tick(S32_MAX, S32_MIN, 0, 0), 1'b0);
      send_tick(tick(S32_MIN, S32_MAX, S32_MAX, S32_MIN), 1'b0);
      send_tick(tick(0, 0, 0, 0), 1'b0);

      // widest hold band, frozen ramp
      drain();
      setting.out_max   = 8'd255;
      setting.hold_band = MAX_POS;
      setting.ramp_step = '0;
      set_gains(setting);
      send_tick(tick(S32_MAX, S32_MIN, 12345, -12345), 1'b0);
      send_tick(tick(0, 0, S32_MAX, S32_MIN), 1'b0);
      send_tick(tick(S32_MIN, S32_MAX, 0, 0), 1'b0);
      send_tick(tick(5, -5, 5, -5), 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         setting = random_gains(p % 4 == 1);
         set_gains(setting);
         if (p == 3) begin
            holds_asked <= holds_asked + 1;
         end
         for (int i = 0; i < PHASE_TICKS; i++) begin
            send_tick(random_tick(), p == 3 && i < BURST_TICKS);
         end
      end

      drain();
      repeat (2 * NUM_STAGES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("dual_wheel_pid_speed_loop_core_tb: done, clean");
      end else begin
         $display("dual_wheel_pid_speed_loop_core_tb: done, errors");
      end
      $finish;
   end

   initial begin : result_sink
      int  stall_left;
      int  span;
      int  holds_served;
      bit  quiet;
      stall_left   = 0;
      span         = 0;
      holds_served = 0;
      quiet        = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            span  = 64;
            quiet = ($urandom_range(0, 3) == 0);
         end
         span--;
         if (stall_left > 0) begin
            stall_left--;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
         if (idle >= IDLE_LIMIT) begin
            $display("dual_wheel_pid_speed_loop_core_tb: done, errors");
            $finish;
         end
      end
   end

endmodule
